// File: hw/rtl/kmst_pkg.sv
package kmst_pkg;

   localparam int IDX_W    = 3;
   localparam int WEIGHT_W = 10;
   localparam int TOTAL_W  = 13;
   localparam int VC_W     = 4;

   localparam logic [WEIGHT_W-1:0] NO_EDGE  = 10'd999;
   localparam logic [TOTAL_W-1:0]  SUM_MAX  = 13'd8191;
   localparam logic [VC_W-1:0]     VC_RESET = 4'd8;

   // sequencer states, one-hot
   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_CLEAR    = 11'b000_0000_0010,
      ST_SCAN     = 11'b000_0000_0100,
      ST_DRAIN    = 11'b000_0000_1000,
      ST_DECIDE   = 11'b000_0001_0000,
      ST_WALK_RD  = 11'b000_0010_0000,
      ST_WALK_CHK = 11'b000_0100_0000,
      ST_UNION    = 11'b000_1000_0000,
      ST_EMIT     = 11'b001_0000_0000,
      ST_REMOVE1  = 11'b010_0000_0000,
      ST_REMOVE2  = 11'b100_0000_0000
   } state_type;

endpackage

// File: hw/rtl/kruskal_min_spanning_tree_core.sv
// Minimum spanning tree engine (Kruskal). Matrix entries (row, column, weight) are
// loaded one item at a time; a weight of 0 (or 999 and up) means no edge. An entry
// without last_entry is only stored, and the block stays idle for the next entry.
// An entry with last_entry is stored and then starts the compute, during which
// req_stall stays high: the parent links of the n vertices are cleared (n =
// vertex_count clamped to 1..MAX_VERTICES), then each round scans the n x n matrix
// one entry per cycle through a single compare unit, walks parent links from both
// edge ends, joins the two trees when they differ and writes the result register
// (waiting while it is full and stalled), and removes the edge and its mirror from
// the matrix. One round runs per scanned edge until n-1 tree edges are found or
// the matrix runs dry. Each tree edge yields one result item; the final one has
// last_result set and connected = 1. When the edges run out early, an extra item
// with edge_valid = 0, connected = 0 and last_result = 1 closes the compute; a
// single vertex gives one such item with connected = 1. total_cost is the running
// sum, saturating at 8191. Matrix entries removed by a compute stay removed;
// reload them before computing again. Reading a matrix entry never written gives
// undefined results. vertex_count is written through csr_write_enable/csr_write_data
// (the user must write it only while the block is idle; the block itself does not
// enforce this).
module kruskal_min_spanning_tree_core #(
   parameter int MAX_VERTICES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // matrix entry items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kmst_pkg::IDX_W-1:0]    req_row_vertex,
   input  logic [kmst_pkg::IDX_W-1:0]    req_column_vertex,
   input  logic [kmst_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                          req_last_entry,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_edge_valid,
   output logic [kmst_pkg::IDX_W-1:0]    rsp_from_vertex,
   output logic [kmst_pkg::IDX_W-1:0]    rsp_to_vertex,
   output logic [kmst_pkg::WEIGHT_W-1:0] rsp_edge_cost,
   output logic [kmst_pkg::TOTAL_W-1:0]  rsp_total_cost,
   output logic                          rsp_connected,
   output logic                          rsp_last_result,
   // vertex_count register
   input  logic                          csr_write_enable,
   input  logic [kmst_pkg::VC_W-1:0]     csr_write_data
);
   import kmst_pkg::*;

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;  // vertex index
   localparam int CW = $clog2(MAX_VERTICES + 1);                      // counts up to n
   localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);           // matrix address

   function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r,
                                                input logic [VW-1:0] c);
      cell_addr = AW'(r) * AW'(MAX_VERTICES) + AW'(c);
   endfunction

   // weight matrix, one write and one registered read per cycle
   logic [WEIGHT_W-1:0] mat_mem [MAX_VERTICES*MAX_VERTICES];
   logic [WEIGHT_W-1:0] mat_rdata_ff;
   logic                mat_we;
   logic [AW-1:0]       mat_waddr;
   logic [WEIGHT_W-1:0] mat_wdata;
   logic [AW-1:0]       mat_raddr;

   // parent links: 0 is root, p means parent is vertex p-1
   logic [CW-1:0] par_mem [MAX_VERTICES];
   logic [CW-1:0] par_rdata_ff;
   logic          par_we;
   logic [VW-1:0] par_waddr;
   logic [CW-1:0] par_wdata;

   // control
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VC_W-1:0]      vc_ff, vc_in;
   logic [CW-1:0]        edges_ff, edges_in;
   logic [TOTAL_W-1:0]   sum_ff, sum_in;
   logic                 rd_vld_ff, rd_vld_in;

   // datapath
   logic [CW-1:0]        n_ff, n_in;
   logic [VW-1:0]        i_ff, i_in, j_ff, j_in;
   logic [VW-1:0]        rd_i_ff, rd_i_in, rd_j_ff, rd_j_in;
   logic [WEIGHT_W-1:0]  best_ff, best_in;
   logic [VW-1:0]        ba_ff, ba_in, bb_ff, bb_in;
   logic [VW-1:0]        clr_ff, clr_in;
   logic [VW-1:0]        walk_v_ff, walk_v_in;
   logic [CW-1:0]        steps_ff, steps_in;
   logic                 side_ff, side_in;
   logic [VW-1:0]        ru_ff, ru_in, rv_ff, rv_in;
   logic                 emit_edge_ff, emit_edge_in;
   logic                 emit_conn_ff, emit_conn_in;
   logic                 emit_last_ff, emit_last_in;

   // result register payload
   logic                 out_edge_ff, out_edge_in;
   logic [IDX_W-1:0]     out_from_ff, out_from_in;
   logic [IDX_W-1:0]     out_to_ff, out_to_in;
   logic [WEIGHT_W-1:0]  out_cost_ff, out_cost_in;
   logic [TOTAL_W-1:0]   out_total_ff, out_total_in;
   logic                 out_conn_ff, out_conn_in;
   logic                 out_last_ff, out_last_in;

   logic                 req_take;
   logic                 rsp_free;
   logic                 in_range;
   logic [CW-1:0]        n_req;
   logic [CW-1:0]        n_last;
   logic [TOTAL_W:0]     sum_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign in_range  = (32'(req_row_vertex) < MAX_VERTICES) &&
                      (32'(req_column_vertex) < MAX_VERTICES);
   assign n_last    = n_ff - CW'(1);
   assign sum_wide  = {1'b0, sum_ff} + (TOTAL_W+1)'(best_ff);

   // vertex count in use, clamped to 1..MAX_VERTICES
   always_comb begin
      if (vc_ff == '0) begin
         n_req = CW'(1);
      end else if (32'(vc_ff) > MAX_VERTICES) begin
         n_req = CW'(MAX_VERTICES);
      end else begin
         n_req = CW'(vc_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      vc_in        = csr_write_enable ? csr_write_data : vc_ff;
      edges_in     = edges_ff;
      sum_in       = sum_ff;
      rd_vld_in    = 1'b0;

      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rd_i_in      = i_ff;
      rd_j_in      = j_ff;
      best_in      = best_ff;
      ba_in        = ba_ff;
      bb_in        = bb_ff;
      clr_in       = clr_ff;
      walk_v_in    = walk_v_ff;
      steps_in     = steps_ff;
      side_in      = side_ff;
      ru_in        = ru_ff;
      rv_in        = rv_ff;
      emit_edge_in = emit_edge_ff;
      emit_conn_in = emit_conn_ff;
      emit_last_in = emit_last_ff;

      out_edge_in  = out_edge_ff;
      out_from_in  = out_from_ff;
      out_to_in    = out_to_ff;
      out_cost_in  = out_cost_ff;
      out_total_in = out_total_ff;
      out_conn_in  = out_conn_ff;
      out_last_in  = out_last_ff;

      mat_we    = 1'b0;
      mat_waddr = cell_addr(VW'(req_row_vertex), VW'(req_column_vertex));
      mat_wdata = req_weight;
      mat_raddr = cell_addr(i_ff, j_ff);
      par_we    = 1'b0;
      par_waddr = clr_ff;
      par_wdata = '0;

      // shared compare unit: data read in the previous scan cycle
      if (rd_vld_ff && mat_rdata_ff != '0 && mat_rdata_ff < best_ff) begin
         best_in = mat_rdata_ff;
         ba_in   = rd_i_ff;
         bb_in   = rd_j_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mat_we = in_range;
               if (req_last_entry) begin
                  n_in     = n_req;
                  edges_in = '0;
                  sum_in   = '0;
                  clr_in   = '0;
                  if (n_req == CW'(1)) begin
                     // single vertex: trivially spanned
                     emit_edge_in = 1'b0;
                     emit_conn_in = 1'b1;
                     emit_last_in = 1'b1;
                     state_in     = ST_EMIT;
                  end else begin
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_CLEAR: begin
            par_we = 1'b1;
            clr_in = clr_ff + VW'(1);
            if (CW'(clr_ff) == n_last) begin
               i_in     = '0;
               j_in     = '0;
               best_in  = NO_EDGE;
               ba_in    = '0;
               bb_in    = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (CW'(j_ff) == n_last) begin
               j_in = '0;
               i_in = i_ff + VW'(1);
               if (CW'(i_ff) == n_last) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               j_in = j_ff + VW'(1);
            end
         end
         ST_DRAIN: begin
            // last compare lands at this edge
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (best_ff == NO_EDGE) begin
               // matrix ran dry before the tree closed
               emit_edge_in = 1'b0;
               emit_conn_in = 1'b0;
               emit_last_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               side_in   = 1'b0;
               walk_v_in = ba_ff;
               steps_in  = '0;
               state_in  = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            if (par_rdata_ff == '0 || steps_ff == n_ff) begin
               if (!side_ff) begin
                  ru_in     = walk_v_ff;
                  side_in   = 1'b1;
                  walk_v_in = bb_ff;
                  steps_in  = '0;
                  state_in  = ST_WALK_RD;
               end else begin
                  rv_in    = walk_v_ff;
                  state_in = ST_UNION;
               end
            end else begin
               walk_v_in = VW'(par_rdata_ff - CW'(1));
               steps_in  = steps_ff + CW'(1);
               state_in  = ST_WALK_RD;
            end
         end
         ST_UNION: begin
            if (ru_ff != rv_ff) begin
               edges_in     = edges_ff + CW'(1);
               sum_in       = sum_wide[TOTAL_W] ? SUM_MAX : sum_wide[TOTAL_W-1:0];
               par_we       = 1'b1;
               par_waddr    = rv_ff;
               par_wdata    = CW'(ru_ff) + CW'(1);
               emit_edge_in = 1'b1;
               emit_conn_in = (edges_ff + CW'(1)) == n_last;
               emit_last_in = (edges_ff + CW'(1)) == n_last;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_REMOVE1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_edge_in  = emit_edge_ff;
               out_from_in  = emit_edge_ff ? IDX_W'(ba_ff) : '0;
               out_to_in    = emit_edge_ff ? IDX_W'(bb_ff) : '0;
               out_cost_in  = emit_edge_ff ? best_ff : '0;
               out_total_in = sum_ff;
               out_conn_in  = emit_conn_ff;
               out_last_in  = emit_last_ff;
               state_in     = emit_edge_ff ? ST_REMOVE1 : ST_IDLE;
            end
         end
         ST_REMOVE1: begin
            mat_we    = 1'b1;
            mat_waddr = cell_addr(ba_ff, bb_ff);
            mat_wdata = '0;
            state_in  = ST_REMOVE2;
         end
         ST_REMOVE2: begin
            mat_we    = 1'b1;
            mat_waddr = cell_addr(bb_ff, ba_ff);
            mat_wdata = '0;
            if (edges_ff == n_last) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = '0;
               j_in     = '0;
               best_in  = NO_EDGE;
               ba_in    = '0;
               bb_in    = '0;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // matrix storage
   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= mat_wdata;
      end
      mat_rdata_ff <= mat_mem[mat_raddr];
   end

   // parent link storage, read address follows the walk pointer
   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_waddr] <= par_wdata;
      end
      par_rdata_ff <= par_mem[walk_v_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vc_ff        <= VC_RESET;
         edges_ff     <= '0;
         sum_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         vc_ff        <= vc_in;
         edges_ff     <= edges_in;
         sum_ff       <= sum_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      rd_i_ff      <= rd_i_in;
      rd_j_ff      <= rd_j_in;
      best_ff      <= best_in;
      ba_ff        <= ba_in;
      bb_ff        <= bb_in;
      clr_ff       <= clr_in;
      walk_v_ff    <= walk_v_in;
      steps_ff     <= steps_in;
      side_ff      <= side_in;
      ru_ff        <= ru_in;
      rv_ff        <= rv_in;
      emit_edge_ff <= emit_edge_in;
      emit_conn_ff <= emit_conn_in;
      emit_last_ff <= emit_last_in;
      out_edge_ff  <= out_edge_in;
      out_from_ff  <= out_from_in;
      out_to_ff    <= out_to_in;
      out_cost_ff  <= out_cost_in;
      out_total_ff <= out_total_in;
      out_conn_ff  <= out_conn_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edge_valid  = out_edge_ff;
   assign rsp_from_vertex = out_from_ff;
   assign rsp_to_vertex   = out_to_ff;
   assign rsp_edge_cost   = out_cost_ff;
   assign rsp_total_cost  = out_total_ff;
   assign rsp_connected   = out_conn_ff;
   assign rsp_last_result = out_last_ff;

endmodule

// File: verif/tb_kruskal_min_spanning_tree_core.sv
module tb_kruskal_min_spanning_tree_core;
   import kmst_pkg::*;

   localparam int MAX_V         = 8;
   localparam int RANDOM_ITEMS  = 245;
   localparam int LONG_HOLD     = 600;    // receiver hold-off for the pressure phase
   localparam int SETTLE_CYCLES = 20;     // block finishes its edge removal after the last item
   localparam int TAIL_CYCLES   = 50;
   localparam int QUIET_LIMIT   = 40000;  // worst compute plus the long hold, several times over
   localparam int PRESSURE_PHASE = 4;

   // kinds of random load sequences
   typedef enum int {
      LOAD_TREE,
      LOAD_SPARSE,
      LOAD_NOISE,
      LOAD_FULL
   } load_kind_type;

   typedef enum logic {
      ROW_CFG,
      ROW_ENTRY
   } plan_kind_type;

   // one result item, field for field
   typedef struct packed {
      logic                edge_valid;
      logic [IDX_W-1:0]    from_v;
      logic [IDX_W-1:0]    to_v;
      logic [WEIGHT_W-1:0] edge_cost;
      logic [TOTAL_W-1:0]  total_cost;
      logic                connected;
      logic                last_result;
   } tree_rsp_type;

   typedef struct {
      plan_kind_type       kind;
      logic [VC_W-1:0]     count;
      logic [IDX_W-1:0]    r;
      logic [IDX_W-1:0]    c;
      logic [WEIGHT_W-1:0] w;
      logic                last;
      logic                typed;
      tree_rsp_type        want;
   } plan_row_type;

   // results that can be read off directly
   localparam tree_rsp_type NO_RSP = '0;
   localparam tree_rsp_type LONE_VERTEX = '{edge_valid: 1'b0, from_v: '0, to_v: '0,
      edge_cost: '0, total_cost: '0, connected: 1'b1, last_result: 1'b1};
   localparam tree_rsp_type MATRIX_DRY = '{edge_valid: 1'b0, from_v: '0, to_v: '0,
      edge_cost: '0, total_cost: '0, connected: 1'b0, last_result: 1'b1};
   localparam tree_rsp_type SPAN_998 = '{edge_valid: 1'b1, from_v: 3'd0, to_v: 3'd1,
      edge_cost: 10'd998, total_cost: 13'd998, connected: 1'b1, last_result: 1'b1};

   localparam int DIRECTED_ROWS = 24;

   // directed table, walked in order
   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      // single vertex, heaviest weight stored on the side
      '{ROW_CFG,   4'd1,  3'd0, 3'd0, 10'd0,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd3, 3'd5, 10'd998,  1'b1, 1'b1, LONE_VERTEX},
      // vertex count zero acts as one
      '{ROW_CFG,   4'd0,  3'd0, 3'd0, 10'd0,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd7, 3'd7, 10'd0,    1'b1, 1'b1, LONE_VERTEX},
      // two vertices, one heaviest edge
      '{ROW_CFG,   4'd2,  3'd0, 3'd0, 10'd0,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd0, 3'd1, 10'd998,  1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd1, 3'd0, 10'd0,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd0, 3'd0, 10'd0,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd1, 3'd1, 10'd0,    1'b1, 1'b1, SPAN_998},
      // the edge was removed by the previous compute
      '{ROW_ENTRY, 4'd0,  3'd1, 3'd1, 10'd0,    1'b1, 1'b1, MATRIX_DRY},
      // sentinel and above count as no edge
      '{ROW_ENTRY, 4'd0,  3'd0, 3'd1, 10'd999,  1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd1, 3'd0, 10'd1023, 1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd0, 3'd0, 10'd0,    1'b1, 1'b1, MATRIX_DRY},
      // count above the maximum clamps, self loop, tie between mirrors
      '{ROW_CFG,   4'd15, 3'd0, 3'd0, 10'd0,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd2, 3'd2, 10'd1,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd4, 3'd5, 10'd7,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd5, 3'd4, 10'd7,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd6, 3'd7, 10'd1,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd7, 3'd6, 10'd0,    1'b1, 1'b0, NO_RSP},
      // triangle of equal weights
      '{ROW_CFG,   4'd3,  3'd0, 3'd0, 10'd0,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd0, 3'd1, 10'd5,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd1, 3'd2, 10'd5,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd0, 3'd2, 10'd5,    1'b0, 1'b0, NO_RSP},
      '{ROW_ENTRY, 4'd0,  3'd2, 3'd2, 10'd0,    1'b1, 1'b0, NO_RSP}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [IDX_W-1:0]    req_row_vertex;
   logic [IDX_W-1:0]    req_column_vertex;
   logic [WEIGHT_W-1:0] req_weight;
   logic                req_last_entry;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_edge_valid;
   logic [IDX_W-1:0]    rsp_from_vertex;
   logic [IDX_W-1:0]    rsp_to_vertex;
   logic [WEIGHT_W-1:0] rsp_edge_cost;
   logic [TOTAL_W-1:0]  rsp_total_cost;
   logic                rsp_connected;
   logic                rsp_last_result;
   logic                csr_write_enable;
   logic [VC_W-1:0]     csr_write_data;

   // shadow of the block: cost matrix, union-find links, running totals
   logic [WEIGHT_W-1:0] cost_grid [MAX_V*MAX_V];
   logic [3:0]          link_up [MAX_V];
   int                  edges_done;
   int                  tree_cost;
   logic [VC_W-1:0]     vc_shadow = VC_RESET;

   tree_rsp_type tree_edges_due [$];   // tree edges awaited, oldest first

   // typed-in expectation for the directed row in flight
   bit           typed_on = 1'b0;
   tree_rsp_type typed_rsp = '0;

   bit hold_request = 1'b0;         // asks the result side for one long hold-off
   int mismatches = 0;
   int quiet_cycles = 0;
   int sent_random = 0;

   kruskal_min_spanning_tree_core #(
      .MAX_VERTICES(MAX_V)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_row_vertex   (req_row_vertex),
      .req_column_vertex(req_column_vertex),
      .req_weight       (req_weight),
      .req_last_entry   (req_last_entry),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_edge_valid   (rsp_edge_valid),
      .rsp_from_vertex  (rsp_from_vertex),
      .rsp_to_vertex    (rsp_to_vertex),
      .rsp_edge_cost    (rsp_edge_cost),
      .rsp_total_cost   (rsp_total_cost),
      .rsp_connected    (rsp_connected),
      .rsp_last_result  (rsp_last_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // vertex count in use: zero acts as one, large values clamp
   function automatic int active_vertices();
      int n;
      n = int'(vc_shadow);
      if (n == 0) n = 1;
      if (n > MAX_V) n = MAX_V;
      return n;
   endfunction

   // follow parent links, bounded by the vertex count
   function automatic int find_root(input int v, input int n);
      int u;
      int steps;
      u = v;
      steps = 0;
      while (link_up[u] != 4'd0 && steps < n) begin
         u = (int'(link_up[u]) - 1) % MAX_V;
         steps++;
      end
      return u;
   endfunction

   // store one entry; on the last one run kruskal over the shadow matrix
   task automatic absorb_entry(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                               input logic [WEIGHT_W-1:0] w, input logic last);
      int n;
      int i;
      int j;
      int a;
      int b;
      int ru;
      int rv;
      logic [WEIGHT_W-1:0] best;
      logic [WEIGHT_W-1:0] grid_w;
      cost_grid[int'(r)*MAX_V + int'(c)] = w;
      if (!last) return;
      n = active_vertices();
      for (i = 0; i < MAX_V; i++) link_up[i] = 4'd0;
      edges_done = 0;
      tree_cost = 0;
      if (n == 1) begin
         tree_edges_due.push_back(LONE_VERTEX);
         return;
      end
      while (edges_done < n - 1) begin
         best = NO_EDGE;
         a = 0;
         b = 0;
         // row-major scan, first minimum wins
         for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
               grid_w = cost_grid[i*MAX_V + j];
               if (grid_w != '0 && grid_w < NO_EDGE && grid_w < best) begin
                  best = grid_w;
                  a = i;
                  b = j;
               end
            end
         end
         // no edge left: disconnected closing item
         if (best == NO_EDGE) begin
            tree_edges_due.push_back(tree_rsp_type'{1'b0, IDX_W'(0), IDX_W'(0), WEIGHT_W'(0),
                                                    TOTAL_W'(tree_cost), 1'b0, 1'b1});
            return;
         end
         ru = find_root(a, n);
         rv = find_root(b, n);
         if (ru != rv) begin
            edges_done++;
            tree_cost += int'(best);
            if (tree_cost > int'(SUM_MAX)) tree_cost = int'(SUM_MAX);
            link_up[rv] = 4'(ru + 1);
            tree_edges_due.push_back(tree_rsp_type'{1'b1, IDX_W'(a), IDX_W'(b), best,
                                                    TOTAL_W'(tree_cost),
                                                    edges_done == n - 1, edges_done == n - 1});
         end
         // scanned edge and its mirror go away either way
         cost_grid[a*MAX_V + b] = '0;
         cost_grid[b*MAX_V + a] = '0;
      end
   endtask

   task automatic check_field(input string what, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   // sample both channels and the register port at the rising edge
   always @(posedge clock) begin : scoreboard
      tree_rsp_type head;
      int due_base;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_write_enable) begin
            vc_shadow = csr_write_data;
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            due_base = tree_edges_due.size();
            absorb_entry(req_row_vertex, req_column_vertex, req_weight, req_last_entry);
            // directed rows with a typed result replace what the shadow computed
            if (typed_on && req_last_entry) begin
               while (tree_edges_due.size() > due_base) void'(tree_edges_due.pop_back());
               tree_edges_due.push_back(typed_rsp);
            end
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (tree_edges_due.size() == 0) begin
               $display("%0t: expected no result, got %0d %0d->%0d cost %0d total %0d %0d %0d",
                        $time, rsp_edge_valid, rsp_from_vertex, rsp_to_vertex,
                        rsp_edge_cost, rsp_total_cost, rsp_connected, rsp_last_result);
               mismatches++;
            end else begin
               head = tree_edges_due.pop_front();
               check_field("edge_valid", int'(head.edge_valid), int'(rsp_edge_valid));
               check_field("from_vertex", int'(head.from_v), int'(rsp_from_vertex));
               check_field("to_vertex", int'(head.to_v), int'(rsp_to_vertex));
               check_field("edge_cost", int'(head.edge_cost), int'(rsp_edge_cost));
               check_field("total_cost", int'(head.total_cost), int'(rsp_total_cost));
               check_field("connected", int'(head.connected), int'(rsp_connected));
               check_field("last_result", int'(head.last_result), int'(rsp_last_result));
            end
            moved = 1'b1;
         end
         // watchdog on cycles with no handshake at all
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, nothing accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // result side: random stall runs, one long hold-off on request
   initial begin : result_sink
      int roll;
      int span;
      rsp_stall = 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall = 1'b1;
            span = LONG_HOLD;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               rsp_stall = 1'b0;
               span = $urandom_range(1, 12);
            end else if (roll < 65) begin
               rsp_stall = 1'b0;
               span = $urandom_range(40, 120);
            end else if (roll < 90) begin
               rsp_stall = 1'b1;
               span = $urandom_range(1, 3);
            end else if (roll < 97) begin
               rsp_stall = 1'b1;
               span = $urandom_range(4, 10);
            end else begin
               rsp_stall = 1'b1;
               span = $urandom_range(20, 40);
            end
         end
         repeat (span) @(negedge clock);
      end
   end

   // idle gap before an item: mostly none, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // weights with the boundaries and the no-edge codes well represented
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return '0;
      if (roll < 20) return WEIGHT_W'($urandom_range(999, 1023));
      if (roll < 25) return 10'd998;
      if (roll < 30) return 10'd1;
      return WEIGHT_W'($urandom_range(1, 998));
   endfunction

   function automatic logic [VC_W-1:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 4'd1;
      if (roll < 15) return 4'd0;
      if (roll < 30) return 4'd8;
      if (roll < 38) return VC_W'($urandom_range(9, 14));
      if (roll < 43) return 4'd15;
      return VC_W'($urandom_range(2, 7));
   endfunction

   // offer one entry at a falling edge, hold it until taken
   task automatic send_entry(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                             input logic [WEIGHT_W-1:0] w, input logic last,
                             input int gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_row_vertex = r;
      req_column_vertex = c;
      req_weight = w;
      req_last_entry = last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // wait for every awaited result, then let the block drain its removal states
   task automatic settle();
      req_valid = 1'b0;
      while (tree_edges_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_vertex_count(input logic [VC_W-1:0] v);
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // one random load sequence, ending in a compute except for noise, which computes only half the time
   task automatic random_phase(input load_kind_type kind);
      int n;
      int i;
      int j;
      int k;
      int extra;
      logic close;
      n = active_vertices();
      case (kind)
         LOAD_TREE: begin
            // random spanning tree so the compute usually connects everything
            for (i = 1; i < n; i++) begin
               j = $urandom_range(0, i - 1);
               if ($urandom_range(0, 1)) begin
                  send_entry(IDX_W'(i), IDX_W'(j), WEIGHT_W'($urandom_range(1, 998)), 1'b0,
                             pick_gap());
               end else begin
                  send_entry(IDX_W'(j), IDX_W'(i), WEIGHT_W'($urandom_range(1, 998)), 1'b0,
                             pick_gap());
               end
               sent_random++;
            end
            extra = $urandom_range(0, 3);
            for (k = 0; k <= extra; k++) begin
               send_entry(IDX_W'($urandom_range(0, n - 1)), IDX_W'($urandom_range(0, n - 1)),
                          pick_weight(), k == extra, pick_gap());
               sent_random++;
            end
         end
         LOAD_SPARSE: begin
            extra = $urandom_range(3, 12);
            for (k = 0; k < extra; k++) begin
               send_entry(IDX_W'($urandom_range(0, n - 1)), IDX_W'($urandom_range(0, n - 1)),
                          pick_weight(), k == extra - 1, pick_gap());
               sent_random++;
            end
         end
         LOAD_NOISE: begin
            // anywhere in the matrix, any weight, and half the time no compute
            extra = $urandom_range(2, 8);
            close = 1'($urandom_range(0, 1));
            for (k = 0; k < extra; k++) begin
               send_entry(IDX_W'($urandom_range(0, MAX_V - 1)),
                          IDX_W'($urandom_range(0, MAX_V - 1)),
                          WEIGHT_W'($urandom_range(0, 1023)),
                          close && k == extra - 1, pick_gap());
               sent_random++;
            end
         end
         default: begin
            // reload the whole active block
            for (i = 0; i < n; i++) begin
               for (j = 0; j < n; j++) begin
                  send_entry(IDX_W'(i), IDX_W'(j), pick_weight(),
                             i == n - 1 && j == n - 1, pick_gap());
                  sent_random++;
               end
            end
         end
      endcase
   endtask

   initial begin : stimulus
      int i;
      int phase;
      int roll;
      load_kind_type kind;
      reset = 1'b1;
      req_valid = 1'b0;
      req_row_vertex = '0;
      req_column_vertex = '0;
      req_weight = '0;
      req_last_entry = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill every matrix entry, computing at the reset vertex count
      for (i = 0; i < MAX_V*MAX_V; i++) begin
         send_entry(IDX_W'(i / MAX_V), IDX_W'(i % MAX_V),
                    $urandom_range(0, 1) ? WEIGHT_W'($urandom_range(1, 998)) : WEIGHT_W'(0),
                    i == MAX_V*MAX_V - 1, pick_gap());
      end

      // directed table
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_plan[i].kind == ROW_CFG) begin
            settle();
            write_vertex_count(directed_plan[i].count);
         end else begin
            typed_on = directed_plan[i].typed;
            typed_rsp = directed_plan[i].want;
            send_entry(directed_plan[i].r, directed_plan[i].c, directed_plan[i].w,
                       directed_plan[i].last, pick_gap());
            typed_on = 1'b0;
         end
      end

      // random load sequences
      phase = 0;
      while (sent_random < RANDOM_ITEMS) begin
         if (phase == PRESSURE_PHASE) begin
            // full-size trees back to back while the result side holds off
            settle();
            write_vertex_count(4'd8);
            hold_request = 1'b1;
            repeat (3) random_phase(LOAD_TREE);
         end else begin
            if ($urandom_range(0, 99) < 55) begin
               settle();
               write_vertex_count(pick_count());
            end
            roll = $urandom_range(0, 99);
            if (roll < 40) kind = LOAD_TREE;
            else if (roll < 70) kind = LOAD_SPARSE;
            else if (roll < 85) kind = LOAD_NOISE;
            else if (active_vertices() <= 4) kind = LOAD_FULL;
            else kind = LOAD_SPARSE;
            random_phase(kind);
         end
         phase++;
      end

      // drain and finish
      req_valid = 1'b0;
      while (tree_edges_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
